// File: hw/rtl/bnca_pkg.sv
// shared types and constants for the batch norm channel affine block
`timescale 1ns / 1ps
package bnca_pkg;
    localparam int MAX_CHANNELS_DEF = 64;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CH_W             = 6;
    localparam int VAL_W            = 32;
    localparam int VAR_W            = 31;
    localparam int EPS_W            = 16;
    localparam int REG_IDX_W        = 1;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_EPSILON = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_RELU    = 1'b1;

    // item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    localparam logic signed [VAL_W-1:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] S32_MIN = 32'sh80000000;

    // one classified item in the queue between front and back
    typedef struct packed {
        logic             func;
        logic             in_range;
        logic [CH_W-1:0]  channel;
        logic [VAL_W-1:0] sample;
        logic [VAL_W-1:0] gain;
        logic [VAL_W-1:0] offset;
        logic [VAL_W-1:0] mean_value;
        logic [VAR_W-1:0] variance;
    } bnca_item_t;
endpackage

// File: hw/rtl/bnca_ram.sv
// generic single write, single registered read ram
`timescale 1ns / 1ps
module bnca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// File: hw/rtl/bnca_front.sv
// front end: accepts items, classifies them and queues them for the back end
`timescale 1ns / 1ps
module bnca_front
    import bnca_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_func,
    input  logic [CH_W-1:0]         s_channel,
    input  logic signed [VAL_W-1:0] s_sample,
    input  logic signed [VAL_W-1:0] s_gain,
    input  logic signed [VAL_W-1:0] s_offset,
    input  logic signed [VAL_W-1:0] s_mean_value,
    input  logic [VAR_W-1:0]        s_variance,
    output logic                    q_valid,
    input  logic                    q_ready,
    output bnca_item_t              q_item
);
    bnca_item_t       slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;
    bnca_item_t       item;

    // classify the incoming item
    always_comb begin
        item.func       = s_func;
        item.in_range   = ({26'd0, s_channel} < 32'(MAX_CHANNELS));
        item.channel    = s_channel;
        item.sample     = s_sample;
        item.gain       = s_gain;
        item.offset     = s_offset;
        item.mean_value = s_mean_value;
        item.variance   = s_variance;
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_item  = slot_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, push} - {1'b0, pop};

    // two entry queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end
endmodule

// File: hw/rtl/bnca_sqrt.sv
// multi cycle unit: alpha and beta for one channel load (sqrt, divide, multiply)
`timescale 1ns / 1ps
module bnca_sqrt
    import bnca_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [EPS_W-1:0]        epsilon,
    input  logic signed [VAL_W-1:0] gain,
    input  logic signed [VAL_W-1:0] offset,
    input  logic signed [VAL_W-1:0] mean_value,
    input  logic [VAR_W-1:0]        variance,
    output logic                    busy,
    output logic                    done,
    output logic [VAL_W-1:0]        alpha,
    output logic [VAL_W-1:0]        beta
);
    localparam int NW  = 64;            // radicand width
    localparam int SW  = 33;            // root width
    localparam int DW  = 64;            // dividend width
    localparam int CW  = 7;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQRT = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_BETA = 6'b010000,
        ST_DONE = 6'b100000
    } st_t;

    st_t                 st_reg;
    logic [CW-1:0]       cnt_reg;
    logic [NW-1:0]       rad_reg;
    logic [SW+1:0]       rem_reg;
    logic [SW-1:0]       root_reg;
    logic [DW-1:0]       num_reg;
    logic [DW:0]         drem_reg;
    logic [DW-1:0]       quo_reg;
    logic                neg_reg;
    logic signed [VAL_W-1:0] gain_reg, off_reg, mean_reg;
    logic signed [VAL_W-1:0] alpha_reg;
    logic signed [63:0]  prod_reg;
    logic [VAL_W-1:0]    beta_reg;

    logic [SW+1:0]       rem_try, trial;
    logic [SW+1:0]       rem_sh;
    logic [DW:0]         drem_sh;
    logic [DW:0]         div_sub;
    logic [SW-1:0]       s_half;
    logic [DW-1:0]       quo_fin;
    logic signed [VAL_W-1:0] alpha_fin;
    logic [32:0]         var_sum;
    logic [31:0]         gmag;
    logic signed [63:0]  rnd;
    logic signed [64:0]  bsum;

    // sqrt: one root bit per cycle (restoring)
    assign rem_sh  = {rem_reg[SW-1:0], rad_reg[NW-1:NW-2]};
    assign trial   = {root_reg, 2'b01};
    assign rem_try = rem_sh - trial;

    // divide: one quotient bit per cycle
    assign drem_sh = {drem_reg[DW-1:0], num_reg[DW-1]};
    assign div_sub = drem_sh - {{(DW+1-SW){1'b0}}, root_reg};

    assign var_sum = {2'b00, variance} + {17'd0, epsilon};
    assign gmag    = gain[VAL_W-1] ? 32'(-gain) : 32'(gain);
    assign s_half  = root_reg >> 1;

    // saturate quotient magnitude to signed 32 bit with sign
    always_comb begin
        quo_fin = quo_reg;
        if (neg_reg) begin
            alpha_fin = (quo_fin > 64'h80000000) ? S32_MIN : 32'(-quo_fin);
        end else begin
            alpha_fin = (quo_fin > 64'h7fffffff) ? S32_MAX : 32'(quo_fin);
        end
    end

    // beta from registered product
    always_comb begin
        rnd  = (prod_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        bsum = 65'(off_reg) - 65'(rnd);
    end

    assign busy  = (st_reg != ST_IDLE);
    assign done  = (st_reg == ST_DONE);
    assign alpha = alpha_reg;
    assign beta  = beta_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            case (st_reg)
                ST_IDLE: begin
                    if (start) begin
                        st_reg   <= ST_SQRT;
                        cnt_reg  <= CW'(NW / 2);
                        rad_reg  <= 64'(var_sum) << FRAC_BITS;
                        rem_reg  <= '0;
                        root_reg <= '0;
                        gain_reg <= gain;
                        off_reg  <= offset;
                        mean_reg <= mean_value;
                        neg_reg  <= gain[VAL_W-1];
                        num_reg  <= 64'(gmag) << FRAC_BITS;
                    end
                end
                ST_SQRT: begin
                    rad_reg <= rad_reg << 2;
                    if (!rem_try[SW+1]) begin
                        rem_reg  <= rem_try;
                        root_reg <= {root_reg[SW-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[SW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) begin
                        st_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == '0) begin
                        // nearest rounding of the root, then rounded divide
                        if (rem_reg > {2'b00, root_reg}) begin
                            root_reg <= root_reg + 1'b1;
                            num_reg  <= num_reg + 64'(({1'b0, root_reg} + 34'd1) >> 1);
                        end else begin
                            num_reg  <= num_reg + 64'(s_half);
                        end
                        drem_reg <= '0;
                        quo_reg  <= '0;
                        cnt_reg  <= CW'(DW + 1);
                        if (root_reg == '0 && rem_reg == '0) begin
                            alpha_reg <= (gain_reg == 0) ? '0 :
                                         (neg_reg ? S32_MIN : S32_MAX);
                            st_reg    <= ST_MUL;
                        end
                    end else if (cnt_reg == CW'(1)) begin
                        alpha_reg <= alpha_fin;
                        st_reg    <= ST_MUL;
                    end else begin
                        num_reg <= num_reg << 1;
                        if (!div_sub[DW]) begin
                            drem_reg <= div_sub;
                            quo_reg  <= {quo_reg[DW-2:0], 1'b1};
                        end else begin
                            drem_reg <= drem_sh;
                            quo_reg  <= {quo_reg[DW-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_MUL: begin
                    prod_reg <= 64'(alpha_reg) * 64'(mean_reg);
                    st_reg   <= ST_BETA;
                end
                ST_BETA: begin
                    if (bsum > 65'(S32_MAX)) begin
                        beta_reg <= S32_MAX;
                    end else if (bsum < 65'(S32_MIN)) begin
                        beta_reg <= S32_MIN;
                    end else begin
                        beta_reg <= bsum[VAL_W-1:0];
                    end
                    st_reg <= ST_DONE;
                end
                ST_DONE: begin
                    st_reg <= ST_IDLE;
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// File: hw/rtl/bnca_back.sv
// back end: runs loads through the sqrt unit and data items through the affine pipe
`timescale 1ns / 1ps
module bnca_back
    import bnca_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [EPS_W-1:0]        epsilon,
    input  logic                    relu_enable,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  bnca_item_t              q_item,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_result_value,
    output logic [CH_W-1:0]         m_result_channel,
    output logic                    m_saturated
);
    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic                 ld_start, ld_busy, ld_done;
    logic [VAL_W-1:0]     ld_alpha, ld_beta;
    logic [AW-1:0]        ld_ch_reg;
    logic [VAL_W-1:0]     a_rd, b_rd;

    // stage 1: ram read
    logic                 s1_v_reg, s1_in_reg;
    logic [CH_W-1:0]      s1_ch_reg;
    logic signed [VAL_W-1:0] s1_x_reg;
    // stage 2: product
    logic                 s2_v_reg, s2_in_reg;
    logic [CH_W-1:0]      s2_ch_reg;
    logic signed [63:0]   s2_p_reg;
    logic signed [VAL_W-1:0] s2_b_reg;
    // output register
    logic                 o_v_reg;
    logic signed [VAL_W-1:0] o_val_reg;
    logic [CH_W-1:0]      o_ch_reg;
    logic                 o_sat_reg;

    logic                 adv, take_data;
    logic signed [63:0]   rnd;
    logic signed [64:0]   sum, sum_r;
    logic signed [VAL_W-1:0] val_n;
    logic                 sat_n;

    // pipe moves when the output slot is free or emptying
    assign adv       = !o_v_reg || m_ready;
    assign take_data = q_valid && q_item.func == FUNC_DATA && adv && !ld_busy;
    assign ld_start  = q_valid && q_item.func == FUNC_LOAD && !ld_busy;
    assign q_ready   = take_data || ld_start;

    bnca_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ld_start),
        .epsilon   (epsilon),
        .gain      (q_item.gain),
        .offset    (q_item.offset),
        .mean_value(q_item.mean_value),
        .variance  (q_item.variance),
        .busy      (ld_busy),
        .done      (ld_done),
        .alpha     (ld_alpha),
        .beta      (ld_beta)
    );

    // loads on out of range channels are dropped at write time
    logic ld_ok_reg;
    always_ff @(posedge aclk) begin
        if (ld_start) begin
            ld_ch_reg <= AW'(q_item.channel);
            ld_ok_reg <= q_item.in_range;
        end
    end

    bnca_ram #(.WIDTH(VAL_W), .DEPTH(MAX_CHANNELS)) u_alpha (
        .aclk(aclk), .wr_en(ld_done && ld_ok_reg), .wr_addr(ld_ch_reg),
        .wr_data(ld_alpha), .rd_en(take_data), .rd_addr(AW'(q_item.channel)),
        .rd_data(a_rd)
    );
    bnca_ram #(.WIDTH(VAL_W), .DEPTH(MAX_CHANNELS)) u_beta (
        .aclk(aclk), .wr_en(ld_done && ld_ok_reg), .wr_addr(ld_ch_reg),
        .wr_data(ld_beta), .rd_en(take_data), .rd_addr(AW'(q_item.channel)),
        .rd_data(b_rd)
    );

    // rounding, relu and saturation
    always_comb begin
        rnd   = (s2_p_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        sum   = s2_in_reg ? (65'(rnd) + 65'(s2_b_reg)) : 65'sd0;
        sum_r = (relu_enable && sum < 0) ? 65'sd0 : sum;
        sat_n = 1'b0;
        if (sum_r > 65'(S32_MAX)) begin
            val_n = S32_MAX;
            sat_n = 1'b1;
        end else if (sum_r < 65'(S32_MIN)) begin
            val_n = S32_MIN;
            sat_n = 1'b1;
        end else begin
            val_n = sum_r[VAL_W-1:0];
        end
    end

    // data pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end else if (adv) begin
            s1_v_reg <= take_data;
            s2_v_reg <= s1_v_reg;
            o_v_reg  <= s2_v_reg;
        end
        if (adv) begin
            s1_in_reg <= q_item.in_range;
            s1_ch_reg <= q_item.channel;
            s1_x_reg  <= q_item.sample;
            s2_in_reg <= s1_in_reg;
            s2_ch_reg <= s1_ch_reg;
            s2_p_reg  <= 64'(signed'(a_rd)) * 64'(s1_x_reg);
            s2_b_reg  <= b_rd;
            o_val_reg <= val_n;
            o_ch_reg  <= s2_ch_reg;
            o_sat_reg <= sat_n;
        end
    end

    assign m_valid          = o_v_reg;
    assign m_result_value   = o_val_reg;
    assign m_result_channel = o_ch_reg;
    assign m_saturated      = o_sat_reg;
endmodule

// File: hw/rtl/batch_norm_channel_affine.sv
// top level of the inference batch normalization block
`timescale 1ns / 1ps
// Data items stream through a four stage pipe (queue, table read, multiply,
// round and saturate) at one item per cycle while the output is not stalled
// and no load is running. A result passes the s1, s2 and output registers
// before it shows on m_valid. A load item keeps the shared sqrt/divide
// sequencer busy after it leaves the queue: 32 root steps, one root rounding
// step, 64 quotient steps and saturation (both skipped for a zero root),
// multiply, beta and the table write. Data items behind it wait in the queue
// until it finishes. The coefficient tables need a load before a channel is read and have no clearing pass.
module batch_norm_channel_affine
    import bnca_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [REG_IDX_W-1:0]    cfg_index,
    input  logic [EPS_W-1:0]        cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_func,
    input  logic [CH_W-1:0]         s_channel,
    input  logic signed [VAL_W-1:0] s_sample,
    input  logic signed [VAL_W-1:0] s_gain,
    input  logic signed [VAL_W-1:0] s_offset,
    input  logic signed [VAL_W-1:0] s_mean_value,
    input  logic [VAR_W-1:0]        s_variance,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_result_value,
    output logic [CH_W-1:0]         m_result_channel,
    output logic                    m_saturated
);
    logic [EPS_W-1:0] eps_reg;
    logic             relu_reg;
    logic             q_valid, q_ready;
    bnca_item_t       q_item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg  <= EPS_W'(1);
            relu_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_EPSILON: eps_reg  <= cfg_data;
                REG_RELU:    relu_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    bnca_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_channel(s_channel), .s_sample(s_sample), .s_gain(s_gain),
        .s_offset(s_offset), .s_mean_value(s_mean_value),
        .s_variance(s_variance),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    bnca_back #(.MAX_CHANNELS(MAX_CHANNELS), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .epsilon(eps_reg), .relu_enable(relu_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_value(m_result_value), .m_result_channel(m_result_channel),
        .m_saturated(m_saturated)
    );

    // a saturated result is never zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_result_value != 0)
        else $error("saturated flag with zero result");

    // with relu on, no negative result leaves the block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && relu_reg |-> !m_result_value[VAL_W-1])
        else $error("negative result with relu enabled");

    // queue full means the front stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_ready && !s_ready |=> !(s_valid && s_ready && !q_ready) || q_valid)
        else $error("queue lost its content");
endmodule
